@@ hw/rtl/rwct_pkg.sv @@
`default_nettype none

package rwct_pkg;

  // Texture and screen geometry
  localparam int TEX_COLS      = 64;
  localparam int TEX_ROWS      = 64;
  localparam int SCREEN_ROWS   = 64;
  localparam int TEX_X_W       = $clog2(TEX_COLS);
  localparam int TEX_Y_W       = $clog2(TEX_ROWS);

  // Field widths
  localparam int ADDR_W        = 12;
  localparam int COLOR_W       = 24;
  localparam int COLUMN_W      = 10;
  localparam int ROW_W         = 6;
  localparam int END_W         = 7;
  localparam int COUNT_W       = 7;
  localparam int DIR_W         = 18;
  localparam int DIST_W        = 24;
  localparam int POSCFG_W      = 24;
  localparam int LH_W          = 16;
  localparam int FRAC_W        = 16;

  // Texture store
  localparam int STORE_DEPTH   = 1 << ADDR_W;

  // Row step: (TEX_ROWS << 16) / wall_height
  localparam int QUOT_W        = TEX_Y_W + FRAC_W + 1;
  localparam int DIV_CNT_W     = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] DIV_NUM = QUOT_W'(TEX_ROWS) << FRAC_W;

  // Texture position accumulator and start offset
  localparam int POS_W         = 32;
  localparam int OFFS_W        = LH_W + 2;
  localparam int HALF_SCREEN   = SCREEN_ROWS / 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Opcodes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_RENDER   = 1'b1;

  // Config register indexes
  localparam logic REG_POS_X   = 1'b0;
  localparam logic REG_POS_Y   = 1'b1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_POS,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_ROWS
  } back_state_e;

  typedef struct packed {
    logic                       is_load;
    logic [ADDR_W-1:0]          texel_addr;
    logic [COLOR_W-1:0]         color;
    logic [COLUMN_W-1:0]        column;
    logic [TEX_X_W-1:0]         tex_x;
    logic signed [POS_W-1:0]    pos;
    logic [QUOT_W-1:0]          step;
    logic [ROW_W-1:0]           first_row;
    logic [COUNT_W-1:0]         count;
  } cmd_t;

  typedef struct packed {
    logic [COLUMN_W-1:0]        column;
    logic [ROW_W-1:0]           row;
    logic                       last;
  } meta_t;

  typedef struct packed {
    logic [COLUMN_W-1:0]        column;
    logic [ROW_W-1:0]           row;
    logic [COLOR_W-1:0]         color;
    logic                       last;
  } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/rwct_divider.sv @@
`default_nettype none

module rwct_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rwct_pkg::LH_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rwct_pkg::QUOT_W-1:0]      quot_o
);
  import rwct_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [LH_W-1:0]       divisor_q, divisor_d;
  logic [LH_W-1:0]       rem_q, rem_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [LH_W:0]         rem_sh;
  logic                  ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    rem_sh    = {rem_q, quot_q[QUOT_W-1]};
    ge        = rem_sh >= {1'b0, divisor_q};
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      divisor_d = divisor_i;
      rem_d     = '0;
      quot_d    = DIV_NUM;
    end else if (busy_q) begin
      rem_d  = ge ? LH_W'(rem_sh - {1'b0, divisor_q}) : LH_W'(rem_sh);
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ hw/rtl/rwct_front.sv @@
`default_nettype none

module rwct_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [rwct_pkg::POSCFG_W-1:0]   cfg_wdata_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            opcode_i,
  input  wire logic [rwct_pkg::ADDR_W-1:0]     texel_address_i,
  input  wire logic [rwct_pkg::COLOR_W-1:0]    texel_color_i,
  input  wire logic [rwct_pkg::COLUMN_W-1:0]   column_i,
  input  wire logic                            hit_side_i,
  input  wire logic signed [rwct_pkg::DIR_W-1:0] dir_x_i,
  input  wire logic signed [rwct_pkg::DIR_W-1:0] dir_y_i,
  input  wire logic [rwct_pkg::DIST_W-1:0]     perp_dist_i,
  input  wire logic [rwct_pkg::LH_W-1:0]       wall_height_i,
  input  wire logic [rwct_pkg::ROW_W-1:0]      span_start_i,
  input  wire logic [rwct_pkg::END_W-1:0]      span_end_i,
  // command queue
  output logic                                 q_push_o,
  output rwct_pkg::cmd_t                       q_cmd_o,
  input  wire logic                            q_full_i
);
  import rwct_pkg::*;

  front_state_e              state_q, state_d;

  logic [POSCFG_W-1:0]       pos_x_q, pos_y_q;

  // captured render item
  logic [COLUMN_W-1:0]       column_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [DIR_W-1:0]   dir_q;
  logic [FRAC_W-1:0]         player_frac_q;
  logic                      mirror_q;
  logic signed [OFFS_W-1:0]  offs_q;
  logic [ROW_W-1:0]          start_q;
  logic [COUNT_W-1:0]        count_q;
  logic [FRAC_W-1:0]         wall_frac_q;
  logic [QUOT_W-1:0]         step_q;
  logic signed [POS_W-1:0]   pos_q;
  logic [TEX_X_W-1:0]        tex_x_q;

  logic                      accept;
  logic                      start_div;
  logic [LH_W-1:0]           lh_adj;
  logic [END_W-1:0]          end_cl;
  logic                      has_rows;
  logic signed [OFFS_W-1:0]  offs_in;
  logic signed [DIST_W+DIR_W:0] wall_prod;
  logic signed [OFFS_W+QUOT_W:0] pos_prod;
  logic [FRAC_W-1:0]         frac;
  logic [TEX_X_W-1:0]        tex_x_raw;
  logic                      div_done;
  logic [QUOT_W-1:0]         div_quot;
  cmd_t                      render_cmd;
  cmd_t                      load_cmd;

  // item classification
  assign lh_adj   = (wall_height_i == '0) ? LH_W'(1) : wall_height_i;
  assign end_cl   = (span_end_i > END_W'(SCREEN_ROWS)) ? END_W'(SCREEN_ROWS) : span_end_i;
  assign has_rows = end_cl > {1'b0, span_start_i};
  assign offs_in  = $signed({{(OFFS_W-ROW_W){1'b0}}, span_start_i})
                    - OFFS_W'(HALF_SCREEN)
                    + $signed({2'b00, 1'b0, lh_adj[LH_W-1:1]});

  assign in_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign start_div  = accept && (opcode_i == OP_RENDER) && has_rows;

  // wall hit and texture column
  assign wall_prod = $signed({1'b0, dist_q}) * dir_q;
  assign pos_prod  = offs_q * $signed({1'b0, step_q});
  assign frac      = FRAC_W'(player_frac_q + wall_frac_q);
  assign tex_x_raw = frac[FRAC_W-1 -: TEX_X_W];

  rwct_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_div),
    .divisor_i (lh_adj),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (start_div) state_d = F_DIV;
      F_DIV:  if (div_done) state_d = F_POS;
      F_POS:  state_d = F_PUSH;
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    load_cmd            = '0;
    load_cmd.is_load    = 1'b1;
    load_cmd.texel_addr = texel_address_i;
    load_cmd.color      = texel_color_i;

    render_cmd           = '0;
    render_cmd.is_load   = 1'b0;
    render_cmd.column    = column_q;
    render_cmd.tex_x     = tex_x_q;
    render_cmd.pos       = pos_q;
    render_cmd.step      = step_q;
    render_cmd.first_row = start_q;
    render_cmd.count     = count_q;

    q_push_o = 1'b0;
    q_cmd_o  = render_cmd;
    if (accept && (opcode_i == OP_LOAD)) begin
      q_push_o = 1'b1;
      q_cmd_o  = load_cmd;
    end else if ((state_q == F_PUSH) && !q_full_i) begin
      q_push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_index_i == REG_POS_X)) pos_x_q <= cfg_wdata_i;
      if (cfg_we_i && (cfg_index_i == REG_POS_Y)) pos_y_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_div) begin
      column_q      <= column_i;
      dist_q        <= perp_dist_i;
      dir_q         <= hit_side_i ? dir_x_i : dir_y_i;
      player_frac_q <= hit_side_i ? pos_x_q[FRAC_W-1:0] : pos_y_q[FRAC_W-1:0];
      mirror_q      <= hit_side_i ? dir_y_i[DIR_W-1]
                                  : (!dir_x_i[DIR_W-1] && (dir_x_i != '0));
      offs_q        <= offs_in;
      start_q       <= span_start_i;
      count_q       <= COUNT_W'(end_cl - {1'b0, span_start_i});
    end
    if (state_q == F_DIV) begin
      wall_frac_q <= wall_prod[2*FRAC_W-1:FRAC_W];
      if (div_done) step_q <= div_quot;
    end
    if (state_q == F_POS) begin
      pos_q   <= pos_prod[POS_W-1:0];
      tex_x_q <= mirror_q ? ~tex_x_raw : tex_x_raw;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwct_queue.sv @@
`default_nettype none

module rwct_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rwct_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output rwct_pkg::cmd_t       cmd_o
);
  import rwct_pkg::*;

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]    cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= QCNT_W'(cnt_q + 1'b1);
        2'b01:   cnt_q <= QCNT_W'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwct_back.sv @@
`default_nettype none

module rwct_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command queue
  input  wire logic                          q_valid_i,
  input  wire rwct_pkg::cmd_t                q_cmd_i,
  output logic                               q_pop_o,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rwct_pkg::COLUMN_W-1:0]      out_column_o,
  output logic [rwct_pkg::ROW_W-1:0]         out_row_o,
  output logic [rwct_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                               last_pixel_o
);
  import rwct_pkg::*;

  back_state_e              state_q, state_d;

  // texture store
  logic [COLOR_W-1:0]       tex_mem [STORE_DEPTH];
  logic [COLOR_W-1:0]       rd_data_q;

  // current column
  logic [COLUMN_W-1:0]      column_q;
  logic [TEX_X_W-1:0]       tex_x_q;
  logic signed [POS_W-1:0]  pos_q;
  logic [QUOT_W-1:0]        step_q;
  logic [ROW_W-1:0]         row_q;
  logic [COUNT_W-1:0]       rem_q;

  // read in flight and output queue
  logic                     inflight_q;
  meta_t                    meta_q;
  out_t                     ofifo_q [2];
  logic                     owr_q, ord_q;
  logic [1:0]               ocnt_q;

  logic                     mem_we;
  logic                     issue;
  logic                     pop_out;
  logic                     can_issue;
  logic [2:0]               occ;
  logic [TEX_Y_W-1:0]       tex_y;
  logic [ADDR_W-1:0]        rd_addr;
  out_t                     ofifo_in;
  out_t                     ohead;

  assign q_pop_o = (state_q == B_IDLE) && q_valid_i;
  assign mem_we  = q_pop_o && q_cmd_i.is_load;

  // room for one more pixel, counting the read in flight
  assign occ       = {1'b0, ocnt_q} + {2'b00, inflight_q};
  assign pop_out   = out_valid_o && out_ready_i;
  assign can_issue = (occ < 3'd2) || pop_out;
  assign issue     = (state_q == B_ROWS) && can_issue;

  // texture row truncated toward zero
  assign tex_y   = TEX_Y_W'(pos_q[FRAC_W +: TEX_Y_W]
                   + {{(TEX_Y_W-1){1'b0}}, (pos_q[POS_W-1] && (pos_q[FRAC_W-1:0] != '0))});
  assign rd_addr = ADDR_W'({tex_y, tex_x_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (q_pop_o && !q_cmd_i.is_load) state_d = B_ROWS;
      B_ROWS: if (issue && (rem_q == COUNT_W'(1))) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      inflight_q <= 1'b0;
      rem_q      <= '0;
    end else begin
      state_q    <= state_d;
      inflight_q <= issue;
      if (q_pop_o && !q_cmd_i.is_load) begin
        rem_q <= q_cmd_i.count;
      end else if (issue) begin
        rem_q <= COUNT_W'(rem_q - 1'b1);
      end
    end
  end

  // row stepping
  always_ff @(posedge clk_i) begin
    if (q_pop_o && !q_cmd_i.is_load) begin
      column_q <= q_cmd_i.column;
      tex_x_q  <= q_cmd_i.tex_x;
      pos_q    <= q_cmd_i.pos;
      step_q   <= q_cmd_i.step;
      row_q    <= q_cmd_i.first_row;
    end else if (issue) begin
      pos_q <= POS_W'(pos_q + $signed({{(POS_W-QUOT_W){1'b0}}, step_q}));
      row_q <= ROW_W'(row_q + 1'b1);
    end
    if (issue) begin
      meta_q.column <= column_q;
      meta_q.row    <= row_q;
      meta_q.last   <= rem_q == COUNT_W'(1);
    end
  end

  // texture store port
  always_ff @(posedge clk_i) begin
    if (mem_we) tex_mem[q_cmd_i.texel_addr] <= q_cmd_i.color;
    if (issue) rd_data_q <= tex_mem[rd_addr];
  end

  // output queue
  always_comb begin
    ofifo_in.column = meta_q.column;
    ofifo_in.row    = meta_q.row;
    ofifo_in.color  = rd_data_q;
    ofifo_in.last   = meta_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (inflight_q) owr_q <= ~owr_q;
      if (pop_out) ord_q <= ~ord_q;
      case ({inflight_q, pop_out})
        2'b10:   ocnt_q <= 2'(ocnt_q + 1'b1);
        2'b01:   ocnt_q <= 2'(ocnt_q - 1'b1);
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (inflight_q) ofifo_q[owr_q] <= ofifo_in;
  end

  assign ohead         = ofifo_q[ord_q];
  assign out_valid_o   = ocnt_q != '0;
  assign out_column_o  = ohead.column;
  assign out_row_o     = ohead.row;
  assign pixel_color_o = ohead.color;
  assign last_pixel_o  = ohead.last;

`ifndef SYNTH
  // output queue plus the read in flight never exceeds two
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 3'd2)
    else $error("output queue overrun");

  // a read in flight always finds a free output slot
  a_inflight_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> (ocnt_q < 2'd2))
    else $error("read data lands in a full output queue");

  // a render command loads its full row count
  a_render_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_cmd_i.is_load) |=>
      (state_q == B_ROWS) && (rem_q == $past(q_cmd_i.count)))
    else $error("render command not started");

  // the last row read returns the engine to idle
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (rem_q == COUNT_W'(1))) |=> (state_q == B_IDLE) && meta_q.last)
    else $error("column did not end on its last row");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/raycast_wall_column_texturer.sv @@
// Raycast wall column texturer. A load item (opcode 0) writes one 24-bit texel into a
// 4096-entry texture store and produces no result; texels must be written before a column
// reads them. A render item (opcode 1) produces one pixel per drawn row, span_start up to
// min(span_end, 64) - 1, with last_pixel set on the final one; an empty span produces
// nothing. The front end takes one item when it is idle and the command queue has room:
// a load is pushed straight into the queue; a render goes from its accept through the
// bit-serial divider that forms the row step, taking the quotient, the start-position
// multiply and the push of the command before the next accept. A two-entry command queue
// then feeds the back end, which picks up one command at a time and then reads one texel
// and emits one pixel per cycle while results are not held back; each read is registered
// and then written into a two-entry output queue. It takes no new command until the last
// row of its column is read. The user must write player_pos_x / player_pos_y through the
// config port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module raycast_wall_column_texturer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_index_i,
  input  wire logic [rwct_pkg::POSCFG_W-1:0]     cfg_wdata_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              opcode_i,
  input  wire logic [rwct_pkg::ADDR_W-1:0]       texel_address_i,
  input  wire logic [rwct_pkg::COLOR_W-1:0]      texel_color_i,
  input  wire logic [rwct_pkg::COLUMN_W-1:0]     column_i,
  input  wire logic                              hit_side_i,
  input  wire logic signed [rwct_pkg::DIR_W-1:0] dir_x_i,
  input  wire logic signed [rwct_pkg::DIR_W-1:0] dir_y_i,
  input  wire logic [rwct_pkg::DIST_W-1:0]       perp_dist_i,
  input  wire logic [rwct_pkg::LH_W-1:0]         wall_height_i,
  input  wire logic [rwct_pkg::ROW_W-1:0]        span_start_i,
  input  wire logic [rwct_pkg::END_W-1:0]        span_end_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [rwct_pkg::COLUMN_W-1:0]          out_column_o,
  output logic [rwct_pkg::ROW_W-1:0]             out_row_o,
  output logic [rwct_pkg::COLOR_W-1:0]           pixel_color_o,
  output logic                                   last_pixel_o
);
  import rwct_pkg::*;

  logic  q_push, q_full, q_valid, q_pop;
  cmd_t  q_cmd_in, q_cmd_out;

  rwct_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .texel_address_i (texel_address_i),
    .texel_color_i   (texel_color_i),
    .column_i        (column_i),
    .hit_side_i      (hit_side_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .perp_dist_i     (perp_dist_i),
    .wall_height_i   (wall_height_i),
    .span_start_i    (span_start_i),
    .span_end_i      (span_end_i),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd_in),
    .q_full_i        (q_full)
  );

  rwct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  rwct_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_raycast_wall_column_texturer.sv @@
`timescale 1ns / 1ps

module tb_raycast_wall_column_texturer;
  import rwct_pkg::*;

  localparam int ITEM_TARGET   = 470;
  localparam int SETTLE_CYCLES = 64;
  localparam int TIMEOUT_NS    = 4_000_000;

  // One input item as the block sees it
  typedef struct {
    logic                    op;
    logic [ADDR_W-1:0]       texel_address;
    logic [COLOR_W-1:0]      texel_color;
    logic [COLUMN_W-1:0]     column;
    logic                    hit_side;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic [DIST_W-1:0]       perp_dist;
    logic [LH_W-1:0]         wall_height;
    logic [ROW_W-1:0]        span_start;
    logic [END_W-1:0]        span_end;
  } wall_item_t;

  // Texture model, player position and the pixels still owed by the block
  class pixel_scoreboard;
    logic [COLOR_W-1:0]  texels [STORE_DEPTH];
    bit                  loaded [STORE_DEPTH];
    logic [POSCFG_W-1:0] pos_x;
    logic [POSCFG_W-1:0] pos_y;
    out_t                pending_pixels[$];
    int                  errors = 0;

    task report(input string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Texel address read for each drawn row of a column, in row order
    function void trace_column(input wall_item_t col_item, ref int unsigned addrs[$]);
      logic signed [63:0] hit_offset;
      logic [FRAC_W-1:0]  frac;
      logic [TEX_X_W-1:0] tex_x;
      longint             height, row_step, tex_pos, tex_row, stop_row;
      addrs.delete();
      // fraction of the wall hit picks the texture column
      if (col_item.hit_side) begin
        hit_offset = longint'(col_item.perp_dist) * longint'(col_item.dir_x);
        frac = pos_x[FRAC_W-1:0] + hit_offset[2*FRAC_W-1:FRAC_W];
      end else begin
        hit_offset = longint'(col_item.perp_dist) * longint'(col_item.dir_y);
        frac = pos_y[FRAC_W-1:0] + hit_offset[2*FRAC_W-1:FRAC_W];
      end
      tex_x = TEX_X_W'((64'(frac) * TEX_COLS) >> FRAC_W);
      if ((!col_item.hit_side && col_item.dir_x > 0) ||
          (col_item.hit_side && col_item.dir_y < 0)) begin
        tex_x = TEX_X_W'(TEX_COLS - 1 - tex_x);
      end
      // texture row walks by TEX_ROWS / wall_height per screen row
      height   = (col_item.wall_height == 0) ? 1 : longint'(col_item.wall_height);
      row_step = (longint'(TEX_ROWS) << FRAC_W) / height;
      tex_pos  = (longint'(col_item.span_start) - SCREEN_ROWS / 2 + height / 2) * row_step;
      stop_row = (col_item.span_end > SCREEN_ROWS) ? SCREEN_ROWS : longint'(col_item.span_end);
      for (longint y = col_item.span_start; y < stop_row; y++) begin
        tex_row = (tex_pos < 0) ? -((-tex_pos) >> FRAC_W) : (tex_pos >> FRAC_W);
        addrs.push_back(int'(tex_row & (TEX_ROWS - 1)) * TEX_COLS + tex_x);
        tex_pos += row_step;
      end
    endfunction

    function void note_item(input wall_item_t col_item);
      int unsigned addrs[$];
      out_t        px;
      if (col_item.op == OP_LOAD) begin
        texels[col_item.texel_address] = col_item.texel_color;
        loaded[col_item.texel_address] = 1'b1;
        return;
      end
      trace_column(col_item, addrs);
      foreach (addrs[k]) begin
        px.column = col_item.column;
        px.row    = ROW_W'(col_item.span_start + k);
        px.color  = texels[addrs[k]];
        px.last   = (k == addrs.size() - 1);
        pending_pixels.push_back(px);
      end
    endfunction

    task check_pixel(input out_t got);
      out_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel with nothing pending: column %0d row %0d",
                         got.column, got.row));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.column !== want.column)
        report($sformatf("out_column %0d, expected %0d", got.column, want.column));
      if (got.row !== want.row)
        report($sformatf("out_row %0d, expected %0d (column %0d)",
                         got.row, want.row, want.column));
      if (got.color !== want.color)
        report($sformatf("pixel_color %06h, expected %06h (column %0d row %0d)",
                         got.color, want.color, want.column, want.row));
      if (got.last !== want.last)
        report($sformatf("last_pixel %0b, expected %0b (column %0d row %0d)",
                         got.last, want.last, want.column, want.row));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_index_i;
  logic [POSCFG_W-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    opcode_i;
  logic [ADDR_W-1:0]       texel_address_i;
  logic [COLOR_W-1:0]      texel_color_i;
  logic [COLUMN_W-1:0]     column_i;
  logic                    hit_side_i;
  logic signed [DIR_W-1:0] dir_x_i;
  logic signed [DIR_W-1:0] dir_y_i;
  logic [DIST_W-1:0]       perp_dist_i;
  logic [LH_W-1:0]         wall_height_i;
  logic [ROW_W-1:0]        span_start_i;
  logic [END_W-1:0]        span_end_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [COLUMN_W-1:0]     out_column_o;
  logic [ROW_W-1:0]        out_row_o;
  logic [COLOR_W-1:0]      pixel_color_o;
  logic                    last_pixel_o;

  pixel_scoreboard board = new();
  bit              quiet_stretch = 1'b0;
  int              sent_items = 0;

  raycast_wall_column_texturer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .texel_address_i (texel_address_i),
    .texel_color_i   (texel_color_i),
    .column_i        (column_i),
    .hit_side_i      (hit_side_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .perp_dist_i     (perp_dist_i),
    .wall_height_i   (wall_height_i),
    .span_start_i    (span_start_i),
    .span_end_i      (span_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_column_o    (out_column_o),
    .out_row_o       (out_row_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random idle cycle, about 9 in 100, except during the quiet stretch
  function automatic bit take_break();
    return !quiet_stretch && ($urandom_range(99) < 9);
  endfunction

  // Every field random; callers overwrite what matters for the opcode
  function automatic wall_item_t random_fields(input logic op);
    wall_item_t w;
    w.op            = op;
    w.texel_address = ADDR_W'($urandom);
    w.texel_color   = COLOR_W'($urandom);
    w.column        = COLUMN_W'($urandom);
    w.hit_side      = 1'($urandom_range(1));
    w.dir_x         = DIR_W'($urandom);
    w.dir_y         = DIR_W'($urandom);
    w.perp_dist     = DIST_W'($urandom);
    w.wall_height   = LH_W'($urandom);
    w.span_start    = ROW_W'($urandom);
    w.span_end      = END_W'($urandom);
    return w;
  endfunction

  function automatic wall_item_t make_load(input logic [ADDR_W-1:0] addr,
                                           input logic [COLOR_W-1:0] color);
    wall_item_t w;
    w = random_fields(OP_LOAD);
    w.texel_address = addr;
    w.texel_color   = color;
    return w;
  endfunction

  function automatic wall_item_t make_render(input logic [COLUMN_W-1:0] column,
                                             input logic side,
                                             input logic signed [DIR_W-1:0] dx,
                                             input logic signed [DIR_W-1:0] dy,
                                             input logic [DIST_W-1:0] pdist,
                                             input logic [LH_W-1:0] lh,
                                             input logic [ROW_W-1:0] first_row,
                                             input logic [END_W-1:0] end_row);
    wall_item_t w;
    w = random_fields(OP_RENDER);
    w.column        = column;
    w.hit_side      = side;
    w.dir_x         = dx;
    w.dir_y         = dy;
    w.perp_dist     = pdist;
    w.wall_height   = lh;
    w.span_start    = first_row;
    w.span_end      = end_row;
    return w;
  endfunction

  // Random column: mixed wall heights, mostly short or longer spans, some empty or past screen
  function automatic wall_item_t random_render();
    wall_item_t w;
    w = random_fields(OP_RENDER);
    case ($urandom_range(3))
      0: w.wall_height = LH_W'($urandom_range(16, 1));
      1: w.wall_height = LH_W'($urandom_range(200, 17));
      2: w.wall_height = LH_W'($urandom_range(128, 32));
      default: w.wall_height = LH_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: w.span_end = END_W'($urandom_range(w.span_start));
      1: w.span_end = END_W'($urandom_range(127, 65));
      2, 3, 4, 5: w.span_end = END_W'(w.span_start + 1 +
                                     $urandom_range((63 - w.span_start) > 11 ?
                                                    11 : (63 - w.span_start)));
      default: w.span_end = END_W'($urandom_range(64, w.span_start + 1));
    endcase
    return w;
  endfunction

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_item(input wall_item_t w);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= w.op;
    texel_address_i <= w.texel_address;
    texel_color_i   <= w.texel_color;
    column_i        <= w.column;
    hit_side_i      <= w.hit_side;
    dir_x_i         <= w.dir_x;
    dir_y_i         <= w.dir_y;
    perp_dist_i     <= w.perp_dist;
    wall_height_i   <= w.wall_height;
    span_start_i    <= w.span_start;
    span_end_i      <= w.span_end;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(w);
    sent_items++;
  endtask

  // Load every texel the column will read that was never written, then render it
  task automatic render_column(input wall_item_t w);
    int unsigned reads[$];
    board.trace_column(w, reads);
    foreach (reads[k]) begin
      if (!board.loaded[reads[k]]) send_item(make_load(ADDR_W'(reads[k]), COLOR_W'($urandom)));
    end
    send_item(w);
  endtask

  // Drop valid, wait for every owed pixel, then give the front end time to finish
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_positions(input logic [POSCFG_W-1:0] x, input logic [POSCFG_W-1:0] y);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_POS_X;
    cfg_wdata_i <= x;
    @(negedge clk_i);
    cfg_index_i <= REG_POS_Y;
    cfg_wdata_i <= y;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.pos_x = x;
    board.pos_y = y;
  endtask

  // Result side: random back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_pixel('{column: out_column_o, row: out_row_o,
                          color: pixel_color_o, last: last_pixel_o});
    end
  end

  // Main stimulus
  initial begin
    wall_item_t  pick;
    wall_item_t  cand;
    int unsigned reads[$];
    int          fewest;
    int          missing;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_POS_X;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_LOAD;
    texel_address_i = '0;
    texel_color_i   = '0;
    column_i        = '0;
    hit_side_i      = 1'b0;
    dir_x_i         = '0;
    dir_y_i         = '0;
    perp_dist_i     = '0;
    wall_height_i   = '0;
    span_start_i    = '0;
    span_end_i      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: position at zero, corner texels, field extremes
    write_positions('0, '0);
    send_item(make_load('1, '0));
    send_item(make_load('0, '1));
    // zero wall height over the full screen
    render_column(make_render('0, 1'b0, '0, '0, '0, '0, 6'd0, 7'd64));
    // y side with negative dy mirrors; height of one row
    render_column(make_render('1, 1'b1, '0, -18'sd1, '0, 16'd1, 6'd0, 7'd64));
    // empty spans: end below start and end equal to start
    render_column(make_render(10'd5, 1'b0, 18'sd100, -18'sd100, 24'h012345, 16'd50,
                              6'd40, 7'd10));
    render_column(make_render(10'd6, 1'b1, -18'sd100, 18'sd100, 24'h012345, 16'd50,
                              6'd20, 7'd20));
    // span past the bottom of the screen
    render_column(make_render(10'd7, 1'b0, -18'sd1, 18'sd1234, 24'h010000, 16'd64,
                              6'd50, 7'd127));
    // single last row, x side with positive dx mirrors, extreme directions
    render_column(make_render(10'd8, 1'b0, 18'sd131071, 18'sh20000, '1, 16'hFFFF,
                              6'd63, 7'd64));
    render_column(make_render(10'd9, 1'b1, 18'sd131071, 18'sd131071, '1, 16'hFFFF,
                              6'd0, 7'd3));
    render_column(make_render(10'd10, 1'b1, 18'sh20000, 18'sh20000, 24'h7FFFFF, 16'h8000,
                              6'd1, 7'd2));
    // short wall: texture position starts negative and truncates toward zero
    render_column(make_render(10'd11, 1'b0, -18'sd65536, 18'sd40000, 24'h028000, 16'd3,
                              6'd0, 7'd6));
    render_column(make_render(10'd12, 1'b1, 18'sd30000, -18'sd20000, 24'h0C0000, 16'd40,
                              6'd12, 7'd20));

    // Random phases, each with its own player position
    for (int phase = 1; phase <= 4; phase++) begin
      wait_for_drain();
      if (phase == 1) write_positions('1, '1);
      else write_positions(POSCFG_W'($urandom), POSCFG_W'($urandom));
      quiet_stretch = (phase == 3);
      while (sent_items < phase * ITEM_TARGET / 4) begin
        if ($urandom_range(99) < 12) begin
          send_item(make_load(ADDR_W'($urandom), COLOR_W'($urandom)));
        end else begin
          // prefer columns whose texels are mostly loaded already
          fewest = -1;
          repeat (8) begin
            cand = random_render();
            board.trace_column(cand, reads);
            missing = 0;
            foreach (reads[k]) if (!board.loaded[reads[k]]) missing++;
            if (fewest < 0 || missing < fewest) begin
              pick   = cand;
              fewest = missing;
            end
          end
          render_column(pick);
        end
      end
    end
    quiet_stretch = 1'b0;

    wait_for_drain();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ raycast_wall_column_texturer.f @@
hw/rtl/rwct_pkg.sv
hw/rtl/rwct_divider.sv
hw/rtl/rwct_front.sv
hw/rtl/rwct_queue.sv
hw/rtl/rwct_back.sv
hw/rtl/raycast_wall_column_texturer.sv
verif/tb_raycast_wall_column_texturer.sv
